[rtl/core/frm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_pkg
// Shared widths, register indexes and reset values of the frame deframer.
// ----------------------------------------------------------------------------
package frm_pkg;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 7;
   localparam int IDX_W     = 6;
   localparam int CSR_IDX_W = 2;

   // default payload store depth
   localparam int MAX_DATA_DEF = 64;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD   = 2'd2;

   // configuration reset values
   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST   = 7'd64;

endpackage

[rtl/core/frm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module frm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, output holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/frame_deframer_sum_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_deframer_sum_check
// Parses two-byte-header frames with an 8-bit additive checksum and emits
// the payload of each good frame.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the parser is hunting or
// collecting a frame; payload bytes go into a MAX_DATA-entry RAM. When the
// checksum byte matches, input is held off (req_tready low) while the
// payload is read back out of the RAM's single read port, one result per
// cycle at full rsp_tready. A zero-length frame gives one result with
// payload byte zero. Frames with a wrong second header byte, a length
// above min(max_payload, MAX_DATA) or a bad checksum vanish without a
// result, and the offending byte is not taken as a new header. No clearing
// pass runs after reset. Registers: 0 header_first, 1 header_second,
// 2 max_payload; other indexes are ignored.
module frame_deframer_sum_check
   import frm_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // input beats
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   // result beats
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [7:0] frame_type, [14:8] frame_length,
                                             // [22:15] payload_byte, [28:23] payload_index
   output logic                 rsp_tlast,   // last_of_frame
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam logic [BYTE_W-1:0] MAX_DATA_B = BYTE_W'(MAX_DATA);

   // parser states
   localparam logic [2:0] ST_HUNT  = 3'd0;
   localparam logic [2:0] ST_HDR2  = 3'd1;
   localparam logic [2:0] ST_TYPE  = 3'd2;
   localparam logic [2:0] ST_LEN   = 3'd3;
   localparam logic [2:0] ST_DATA  = 3'd4;
   localparam logic [2:0] ST_CSUM  = 3'd5;
   localparam logic [2:0] ST_DRAIN = 3'd6;

   logic [BYTE_W-1:0] hdr_first_ff, hdr_first_in;
   logic [BYTE_W-1:0] hdr_second_ff, hdr_second_in;
   logic [LEN_W-1:0]  max_pay_ff, max_pay_in;

   logic [2:0]        state_ff, state_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_type_ff, out_type_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;
   logic              out_zero_ff, out_zero_in;

   logic              in_beat;
   logic              adv;
   logic [BYTE_W-1:0] limit;
   logic [BYTE_W-1:0] cnt_next;
   logic [BYTE_W-1:0] len_ext;
   logic              ram_we;
   logic              ram_re;
   logic [BYTE_W-1:0] ram_q;

   assign req_tready = (state_ff != ST_DRAIN);
   assign in_beat    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign cnt_next   = cnt_ff + 8'd1;
   assign len_ext    = {1'b0, len_ff};
   assign limit      = ({1'b0, max_pay_ff} > MAX_DATA_B) ? MAX_DATA_B : {1'b0, max_pay_ff};

   // configuration registers
   always_comb begin
      hdr_first_in  = hdr_first_ff;
      hdr_second_in = hdr_second_ff;
      max_pay_in    = max_pay_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEADER_FIRST:  hdr_first_in  = csr_data;
            CSR_HEADER_SECOND: hdr_second_in = csr_data;
            CSR_MAX_PAYLOAD:   max_pay_in    = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // parser and drain sequencer
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_type_in  = out_type_ff;
      out_len_in   = out_len_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      out_zero_in  = out_zero_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      case (state_ff)
         ST_HUNT: begin
            if (in_beat && req_tdata == hdr_first_ff) begin
               state_in = ST_HDR2;
            end
         end
         ST_HDR2: begin
            if (in_beat) begin
               state_in = (req_tdata == hdr_second_ff) ? ST_TYPE : ST_HUNT;
            end
         end
         ST_TYPE: begin
            if (in_beat) begin
               type_in  = req_tdata;
               sum_in   = req_tdata;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (in_beat) begin
               if (req_tdata > limit) begin
                  state_in = ST_HUNT;
               end else begin
                  len_in   = req_tdata[LEN_W-1:0];
                  sum_in   = sum_ff + req_tdata;
                  cnt_in   = '0;
                  state_in = (req_tdata == '0) ? ST_CSUM : ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (in_beat) begin
               ram_we = 1'b1;
               sum_in = sum_ff + req_tdata;
               cnt_in = cnt_next;
               if (cnt_next == len_ext) begin
                  state_in = ST_CSUM;
               end
            end
         end
         ST_CSUM: begin
            if (in_beat) begin
               cnt_in   = '0;
               state_in = (req_tdata == sum_ff) ? ST_DRAIN : ST_HUNT;
            end
         end
         ST_DRAIN: begin
            // one result per free output slot; the ram output holds when stalled
            if (adv) begin
               ram_re       = (len_ff != '0);
               rsp_valid_in = 1'b1;
               out_type_in  = type_ff;
               out_len_in   = len_ff;
               out_idx_in   = cnt_ff[IDX_W-1:0];
               out_zero_in  = (len_ff == '0);
               out_last_in  = (len_ff == '0) || (cnt_next == len_ext);
               cnt_in       = cnt_next;
               if (out_last_in) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: state_in = ST_HUNT;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= HEADER_FIRST_RST;
         hdr_second_ff <= HEADER_SECOND_RST;
         max_pay_ff    <= MAX_PAYLOAD_RST;
         state_ff      <= ST_HUNT;
         type_ff       <= '0;
         len_ff        <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hdr_first_ff  <= hdr_first_in;
         hdr_second_ff <= hdr_second_in;
         max_pay_ff    <= max_pay_in;
         state_ff      <= state_in;
         type_ff       <= type_in;
         len_ff        <= len_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      out_type_ff <= out_type_in;
      out_len_ff  <= out_len_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      out_zero_ff <= out_zero_in;
   end

   // payload store
   frm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_DATA)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'b000, out_idx_ff, (out_zero_ff ? 8'h00 : ram_q),
                        out_len_ff, out_type_ff};

`ifndef SYNTH
   // payload writes never run past the frame length or the store
   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> (cnt_ff < len_ext && len_ext <= MAX_DATA_B))
      else $error("payload count out of range");

   // drain only starts after a checksum byte equal to the running sum
   a_drain_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CSUM && in_beat && req_tdata != sum_ff) |=> (state_ff == ST_HUNT))
      else $error("bad checksum did not drop frame");

   // drain never reads beyond the stored payload
   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (len_ff == '0 || cnt_ff < len_ext))
      else $error("drain pointer out of range");
`endif

endmodule

[tb/frm_sum_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_sum_checker
// Watches the byte, result and register channels of the frame deframer,
// predicts the payload results of every good frame and compares them.
// ----------------------------------------------------------------------------
module frm_sum_checker
   import frm_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [31:0]          rsp_tdata,   // [7:0] frame_type, [14:8] frame_length,
                                             // [22:15] payload_byte, [28:23] payload_index
   input  logic                 rsp_tlast,   // last_of_frame
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output int                   fail_count,
   output int                   pending,
   output int                   result_count,
   output int                   frame_count
);

   typedef struct packed {
      logic [BYTE_W-1:0] ftype;
      logic [LEN_W-1:0]  flen;
      logic [BYTE_W-1:0] pbyte;
      logic [IDX_W-1:0]  pidx;
      logic              last;
   } payload_beat_type;

   // payload beats still owed by the block, oldest first
   payload_beat_type payload_due_q[$];

   // register copy
   logic [BYTE_W-1:0] hdr_first;
   logic [BYTE_W-1:0] hdr_second;
   logic [LEN_W-1:0]  len_limit;

   // parser copy
   logic [6:0]        rx_pos;
   logic [BYTE_W-1:0] cur_type;
   logic [LEN_W-1:0]  cur_len;
   logic [BYTE_W-1:0] cur_sum;
   logic [BYTE_W-1:0] payload_mem [MAX_DATA];

   // advance the parser by one received byte, queue payload beats of a good frame
   task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
      int               lim;
      int               k;
      payload_beat_type pb;
      case (rx_pos)
         7'd0: begin
            if (b == hdr_first) rx_pos = 7'd1;
         end
         7'd1: begin
            rx_pos = (b == hdr_second) ? 7'd2 : 7'd0;
         end
         7'd2: begin
            cur_type = b;
            cur_sum  = b;
            rx_pos   = 7'd3;
         end
         7'd3: begin
            lim = (int'(len_limit) > MAX_DATA) ? MAX_DATA : int'(len_limit);
            if (int'(b) > lim) begin
               rx_pos = 7'd0;
            end else begin
               cur_len = b[LEN_W-1:0];
               cur_sum = cur_sum + b;
               rx_pos  = 7'd4;
            end
         end
         default: begin
            k = int'(rx_pos) - 4;
            if (k < int'(cur_len) && k < MAX_DATA) begin
               payload_mem[k] = b;
               cur_sum        = cur_sum + b;
               rx_pos         = rx_pos + 7'd1;
            end else begin
               // checksum byte, frame ends here either way
               rx_pos = 7'd0;
               if (k == int'(cur_len) && b == cur_sum) begin
                  frame_count++;
                  if (cur_len == '0) begin
                     pb = '{cur_type, cur_len, '0, '0, 1'b1};
                     payload_due_q.push_back(pb);
                  end else begin
                     for (int i = 0; i < int'(cur_len) && i < MAX_DATA; i++) begin
                        pb = '{cur_type, cur_len, payload_mem[i], IDX_W'(i),
                               (i + 1 == int'(cur_len))};
                        payload_due_q.push_back(pb);
                     end
                  end
               end
            end
         end
      endcase
   endtask

   initial begin
      fail_count   = 0;
      pending      = 0;
      result_count = 0;
      frame_count  = 0;
   end

   always @(posedge clock) begin
      payload_beat_type got;
      payload_beat_type want;
      if (reset) begin
         hdr_first  = HEADER_FIRST_RST;
         hdr_second = HEADER_SECOND_RST;
         len_limit  = MAX_PAYLOAD_RST;
         rx_pos     = '0;
         cur_type   = '0;
         cur_len    = '0;
         cur_sum    = '0;
         payload_due_q.delete();
      end else begin
         // result beats against the oldest owed beat
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            got = '{rsp_tdata[7:0], rsp_tdata[14:8], rsp_tdata[22:15],
                    rsp_tdata[28:23], rsp_tlast};
            if (payload_due_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result beat type %02h len %0d byte %02h idx %0d last %0b",
                           $realtime, got.ftype, got.flen, got.pbyte, got.pidx, got.last);
            end else begin
               want = payload_due_q.pop_front();
               if (got.ftype !== want.ftype || got.flen !== want.flen ||
                   got.pbyte !== want.pbyte || got.pidx !== want.pidx ||
                   got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: result mismatch: expected type %02h len %0d byte %02h ",
                               "idx %0d last %0b, got type %02h len %0d byte %02h idx %0d last %0b"},
                              $realtime, want.ftype, want.flen, want.pbyte, want.pidx,
                              want.last, got.ftype, got.flen, got.pbyte, got.pidx, got.last);
               end
            end
         end
         // received bytes, seen with the register values before this edge
         if (req_tvalid && req_tready) parse_rx_byte(req_tdata);
         // register writes take effect from the next byte
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEADER_FIRST:  hdr_first  = csr_data;
               CSR_HEADER_SECOND: hdr_second = csr_data;
               CSR_MAX_PAYLOAD:   len_limit  = csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      pending = payload_due_q.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame deframer regression: directed frames for the sync, length and
// checksum corner cases, then random frame streams under four register
// settings with random stalls on both sides; a side checker scores results.
// ----------------------------------------------------------------------------
module tb;
   import frm_pkg::*;

   localparam int                   HOLD_CYCLES  = 400;
   localparam int                   PHASE_BYTES  = 20;
   localparam int                   SETTLE_CYCLES = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SECOND,
      FRAME_TOO_LONG,
      FRAME_BAD_SUM
   } frame_kind_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [BYTE_W-1:0]    csr_data   = '0;

   int fail_count;
   int pending;
   int result_count;
   int frame_count;

   // stimulus-side knobs
   bit                idle_on    = 1'b1;
   int                hold_asked = 0;
   int                bytes_sent = 0;
   int                cfg_count  = 1;
   logic [BYTE_W-1:0] cur_hf     = HEADER_FIRST_RST;
   logic [BYTE_W-1:0] cur_hs     = HEADER_SECOND_RST;
   int                cur_lim    = MAX_DATA_DEF;

   frame_deframer_sum_check u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   frm_sum_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count),
      .frame_count  (frame_count)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // result side: random back-pressure plus long hold-offs on request
   initial begin
      int hold_seen;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= idle_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
         end
      end
   end

   // offer one byte, with random gaps, until it is taken
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while (idle_on && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // register write beat; caller drops csr_valid after its last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // stop sending, wait for every owed result, then let the parser settle
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input logic [BYTE_W-1:0] hf, input logic [BYTE_W-1:0] hs,
                               input logic [BYTE_W-1:0] maxraw);
      drain_block();
      write_csr(CSR_HEADER_FIRST, hf);
      write_csr(CSR_HEADER_SECOND, hs);
      write_csr(CSR_MAX_PAYLOAD, maxraw);
      csr_valid <= 1'b0;
      cur_hf  = hf;
      cur_hs  = hs;
      cur_lim = (int'(maxraw[LEN_W-1:0]) > MAX_DATA_DEF) ? MAX_DATA_DEF
                                                         : int'(maxraw[LEN_W-1:0]);
      cfg_count++;
   endtask

   // one frame under the current headers; broken kinds stop where the parser drops
   task automatic send_frame(input frame_kind_type kind, input int len);
      logic [BYTE_W-1:0] ftype;
      logic [BYTE_W-1:0] fsum;
      logic [BYTE_W-1:0] b;
      ftype = BYTE_W'($urandom);
      send_byte(cur_hf);
      if (kind == FRAME_BAD_SECOND) begin
         // sometimes repeat the first header to catch a re-examined byte
         if (cur_hf != cur_hs && $urandom_range(0, 1) == 1) begin
            b = cur_hf;
         end else begin
            do b = BYTE_W'($urandom); while (b == cur_hs);
         end
         send_byte(b);
         return;
      end
      send_byte(cur_hs);
      send_byte(ftype);
      send_byte(BYTE_W'(len));
      if (kind == FRAME_TOO_LONG) return;
      fsum = ftype + BYTE_W'(len);
      for (int i = 0; i < len; i++) begin
         b    = BYTE_W'($urandom);
         fsum = fsum + b;
         send_byte(b);
      end
      if (kind == FRAME_BAD_SUM) fsum = fsum ^ BYTE_W'($urandom_range(1, 255));
      send_byte(fsum);
   endtask

   // random frame mix, mostly good frames with short payloads
   task automatic send_random_frames(input int nbytes);
      int          start;
      int          pick;
      int          len;
      logic [BYTE_W-1:0] b;
      start = bytes_sent;
      while (bytes_sent - start < nbytes) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur_lim)
                                            : $urandom_range(0, (cur_lim < 6) ? cur_lim : 6);
         if (pick < 70) begin
            send_frame(FRAME_GOOD, len);
         end else if (pick < 78) begin
            send_frame(FRAME_BAD_SUM, len);
         end else if (pick < 85) begin
            send_frame(FRAME_BAD_SECOND, 0);
         end else if (pick < 92) begin
            send_frame(FRAME_TOO_LONG, $urandom_range(cur_lim + 1, 255));
         end else begin
            // line noise between frames
            repeat ($urandom_range(1, 3)) begin
               do b = BYTE_W'($urandom); while (b == cur_hf);
               send_byte(b);
            end
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      logic [BYTE_W-1:0] directed_q[$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under reset settings: empty frame, all-ones payload,
      // repeated first header as wrong second header, over-long, bad checksum
      directed_q = {8'hAA, 8'h55, 8'h00, 8'h00, 8'h00,
                    8'hAA, 8'h55, 8'hFF, 8'h01, 8'hFF, 8'hFF,
                    8'hAA, 8'hAA, 8'h55, 8'h5A, 8'h00, 8'h5A,
                    8'hAA, 8'h55, 8'h12, 8'h41,
                    8'hAA, 8'h55, 8'h07, 8'h01, 8'h33, 8'h00};
      foreach (directed_q[i]) send_byte(directed_q[i]);

      // second header changed between the two sync bytes
      send_byte(8'hAA);
      drain_block();
      write_csr(CSR_HEADER_SECOND, 8'h3C);
      csr_valid <= 1'b0;
      cur_hs = 8'h3C;
      directed_q = {8'h3C, 8'h09, 8'h00, 8'h09};
      foreach (directed_q[i]) send_byte(directed_q[i]);

      // zero first header, all-ones second header, wide limit above the store size, ignored index, long hold-off
      apply_config(8'h00, 8'hFF, 8'hFF);
      write_csr(CSR_UNUSED, 8'h77);
      csr_valid <= 1'b0;
      hold_asked++;
      send_frame(FRAME_GOOD, MAX_DATA_DEF);
      send_frame(FRAME_TOO_LONG, MAX_DATA_DEF + 1);
      send_random_frames(PHASE_BYTES);

      // all-ones first header, zero limit: only empty frames pass
      apply_config(8'hFF, 8'h00, 8'h00);
      send_random_frames(PHASE_BYTES);

      // random headers and limit, no idling on either side
      apply_config(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom_range(1, 63)));
      idle_on = 1'b0;
      send_random_frames(PHASE_BYTES);
      idle_on = 1'b1;

      // reset headers, limit written with a stray top bit, full-size frame
      apply_config(8'hAA, 8'h55, 8'hC0);
      send_frame(FRAME_GOOD, MAX_DATA_DEF);
      send_random_frames(PHASE_BYTES);

      drain_block();
      $display("covered %0d received bytes over %0d register settings",
               bytes_sent, cfg_count);
      $display("%0d frames passed the checksum, %0d payload beats checked",
               frame_count, result_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
